// ===== hdl/pooled_linked_list_manager_assert.svh =====
// Assertion macros for the pooled linked list manager.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef POOLED_LINKED_LIST_MANAGER_ASSERT_SVH
`define POOLED_LINKED_LIST_MANAGER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PLLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define PLLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pllm_pkg.sv =====
// Shared constants and types for the pooled linked list manager.
// No dependencies; used by pllm_step and the top level.
package pllm_pkg;

  localparam int POOL_NODES_DEF = 64;
  localparam int VALUE_W        = 32;

  // Request opcodes
  localparam logic [1:0] OP_INS_AFTER = 2'd0;
  localparam logic [1:0] OP_DEL_AFTER = 2'd1;
  localparam logic [1:0] OP_APPEND    = 2'd2;
  localparam logic [1:0] OP_DEL_TAIL  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOSUC = 2'd3;

  // Status of one link step
  typedef struct packed {
    logic is_nil;  // normalized link is the end marker
    logic more;    // walk continues: link not nil and step budget left
  } step_flags_t;

endpackage

// ===== hdl/pllm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pllm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pllm_step.sv =====
// Shared link step unit: normalizes a link word read from the link RAM,
// checks for the end marker and advances the walk step count. Uses pllm_pkg.
module pllm_step #(
  parameter int POOL_NODES = pllm_pkg::POOL_NODES_DEF
) (
  input  logic [$clog2(POOL_NODES+1)-1:0] link_word,
  input  logic [$clog2(POOL_NODES+1)-1:0] steps,
  output logic [$clog2(POOL_NODES+1)-1:0] ptr,
  output logic [$clog2(POOL_NODES+1)-1:0] steps_inc,
  output pllm_pkg::step_flags_t           flags
);

  localparam int PTR_W = $clog2(POOL_NODES+1);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

  always_comb begin
    // any out-of-pool link counts as the end marker
    ptr          = (link_word < NIL) ? link_word : NIL;
    flags.is_nil = (ptr == NIL);
    flags.more   = !flags.is_nil && (steps < NIL);
    steps_inc    = steps + PTR_W'(1);
  end

endmodule

// ===== hdl/pooled_linked_list_manager.sv =====
// Pooled singly linked list with free list: one list and a free list of nodes
// kept in a link RAM and a value RAM. Uses pllm_pkg, pllm_ram, pllm_step.
//
// Usage:
//   A request (opcode, at_head, pred_index, item_value) is transferred at a
//   rising edge with start high and busy low. Exactly one result (status,
//   node_index, node_value, list_head, free_head) follows, valid for the one
//   cycle in which done is high; the receiver cannot stall it. busy is low
//   in that same cycle, so the next request may be transferred then.
//   Append and delete tail walk the list from the head, one link RAM read per
//   walk step, over 1 to POOL_NODES links.
//   Reset: head is empty, the free list holds all nodes in order. After rst
//   drops, busy stays high during a clearing pass that writes the initial
//   links and sets every value to -1.
`include "pooled_linked_list_manager_assert.svh"

module pooled_linked_list_manager #(
  parameter int POOL_NODES = pllm_pkg::POOL_NODES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           opcode,
  input  logic                                 at_head,
  input  logic [$clog2(POOL_NODES)-1:0]        pred_index,
  input  logic signed [pllm_pkg::VALUE_W-1:0]  item_value,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic [$clog2(POOL_NODES)-1:0]        node_index,
  output logic signed [pllm_pkg::VALUE_W-1:0]  node_value,
  output logic [$clog2(POOL_NODES+1)-1:0]      list_head,
  output logic [$clog2(POOL_NODES+1)-1:0]      free_head
);

  localparam int IDX_W = $clog2(POOL_NODES);
  localparam int PTR_W = $clog2(POOL_NODES+1);
  localparam int VAL_W = pllm_pkg::VALUE_W;
  localparam logic [PTR_W-1:0] NIL  = PTR_W'(POOL_NODES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(POOL_NODES-1);

  typedef enum logic [11:0] {
    S_CLEAR      = 12'b0000_0000_0001,
    S_IDLE       = 12'b0000_0000_0010,
    S_DISP       = 12'b0000_0000_0100,
    S_FREE_RD    = 12'b0000_0000_1000,
    S_INS_PRED   = 12'b0000_0001_0000,
    S_INS_LINK   = 12'b0000_0010_0000,
    S_PRED_RD    = 12'b0000_0100_0000,
    S_DEL_RD     = 12'b0000_1000_0000,
    S_GIVE       = 12'b0001_0000_0000,
    S_CUT        = 12'b0010_0000_0000,
    S_WALK_START = 12'b0100_0000_0000,
    S_WALK       = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  logic [PTR_W-1:0] head_ptr, head_next;
  logic [PTR_W-1:0] free_ptr, free_next;
  logic [IDX_W-1:0] clr_idx, clr_next;
  logic [IDX_W-1:0] n_idx, n_next;
  logic [IDX_W-1:0] prev, prev_next;
  logic [PTR_W-1:0] pprev, pprev_next;
  logic [PTR_W-1:0] steps, steps_next;
  logic [VAL_W-1:0] val_reg, val_next;

  logic [1:0]       req_op;
  logic             req_at_head;
  logic [IDX_W-1:0] req_pred;
  logic [VAL_W-1:0] req_item;

  logic             done_next;
  logic [1:0]       res_status, res_status_next;
  logic [IDX_W-1:0] res_node, res_node_next;
  logic [VAL_W-1:0] res_val, res_val_next;
  logic [PTR_W-1:0] res_head, res_head_next;
  logic [PTR_W-1:0] res_free, res_free_next;

  logic             finish;
  logic [1:0]       fin_status;
  logic [IDX_W-1:0] fin_node;
  logic [VAL_W-1:0] fin_val;
  logic             bad_pred;

  // RAM ports
  logic [IDX_W-1:0] rd_addr;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [PTR_W-1:0] link_wdata;
  logic [PTR_W-1:0] link_rdata;
  logic             val_we;
  logic [IDX_W-1:0] val_waddr;
  logic [VAL_W-1:0] val_wdata;
  logic [VAL_W-1:0] val_rdata;

  // step unit
  logic [PTR_W-1:0]      step_ptr;
  logic [PTR_W-1:0]      step_inc;
  pllm_pkg::step_flags_t step_flags;

  pllm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  pllm_ram #(.WIDTH(VAL_W), .DEPTH(POOL_NODES)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  pllm_step #(.POOL_NODES(POOL_NODES)) u_step (
    .link_word (link_rdata),
    .steps     (steps),
    .ptr       (step_ptr),
    .steps_inc (step_inc),
    .flags     (step_flags)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    head_next  = head_ptr;
    free_next  = free_ptr;
    clr_next   = clr_idx;
    n_next     = n_idx;
    prev_next  = prev;
    pprev_next = pprev;
    steps_next = steps;
    val_next   = val_reg;
    rd_addr    = '0;
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    val_we     = 1'b0;
    val_waddr  = '0;
    val_wdata  = '0;
    finish     = 1'b0;
    fin_status = pllm_pkg::ST_OK;
    fin_node   = '0;
    fin_val    = '0;
    bad_pred   = ((req_op == pllm_pkg::OP_INS_AFTER) || (req_op == pllm_pkg::OP_DEL_AFTER))
                 && !req_at_head && (PTR_W'(req_pred) >= NIL);

    case (state)
      S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_idx;
        link_wdata = PTR_W'(clr_idx) + PTR_W'(1);
        val_we     = 1'b1;
        val_waddr  = clr_idx;
        val_wdata  = '1;
        if (clr_idx == LAST) begin
          state_next = S_IDLE;
        end else begin
          clr_next = clr_idx + IDX_W'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          state_next = S_DISP;
        end
      end

      S_DISP: begin
        if (bad_pred) begin
          finish     = 1'b1;
          fin_status = pllm_pkg::ST_NOSUC;
        end else begin
          case (req_op)
            pllm_pkg::OP_INS_AFTER, pllm_pkg::OP_APPEND: begin
              if (free_ptr == NIL) begin
                finish     = 1'b1;
                fin_status = pllm_pkg::ST_FULL;
              end else begin
                n_next     = free_ptr[IDX_W-1:0];
                rd_addr    = free_ptr[IDX_W-1:0];
                state_next = S_FREE_RD;
              end
            end
            pllm_pkg::OP_DEL_AFTER: begin
              if (head_ptr == NIL) begin
                finish     = 1'b1;
                fin_status = pllm_pkg::ST_EMPTY;
              end else if (req_at_head) begin
                n_next     = head_ptr[IDX_W-1:0];
                rd_addr    = head_ptr[IDX_W-1:0];
                state_next = S_DEL_RD;
              end else begin
                rd_addr    = req_pred;
                state_next = S_PRED_RD;
              end
            end
            default: begin
              // delete tail
              if (head_ptr == NIL) begin
                finish     = 1'b1;
                fin_status = pllm_pkg::ST_EMPTY;
              end else begin
                state_next = S_WALK_START;
              end
            end
          endcase
        end
      end

      S_FREE_RD: begin
        // unlink the allocated node from the free list
        free_next = step_ptr;
        val_we    = 1'b1;
        val_waddr = n_idx;
        val_wdata = req_item;
        if (req_op == pllm_pkg::OP_APPEND) begin
          link_we    = 1'b1;
          link_waddr = n_idx;
          link_wdata = NIL;
          if (head_ptr == NIL) begin
            head_next = PTR_W'(n_idx);
            finish    = 1'b1;
            fin_node  = n_idx;
            fin_val   = req_item;
          end else begin
            state_next = S_WALK_START;
          end
        end else if (req_at_head) begin
          link_we    = 1'b1;
          link_waddr = n_idx;
          link_wdata = head_ptr;
          head_next  = PTR_W'(n_idx);
          finish     = 1'b1;
          fin_node   = n_idx;
          fin_val    = req_item;
        end else begin
          rd_addr    = req_pred;
          state_next = S_INS_PRED;
        end
      end

      S_INS_PRED: begin
        link_we    = 1'b1;
        link_waddr = n_idx;
        link_wdata = step_ptr;
        state_next = S_INS_LINK;
      end

      S_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = req_pred;
        link_wdata = PTR_W'(n_idx);
        finish     = 1'b1;
        fin_node   = n_idx;
        fin_val    = req_item;
      end

      S_PRED_RD: begin
        if (step_flags.is_nil) begin
          finish     = 1'b1;
          fin_status = pllm_pkg::ST_NOSUC;
        end else begin
          n_next     = step_ptr[IDX_W-1:0];
          rd_addr    = step_ptr[IDX_W-1:0];
          state_next = S_DEL_RD;
        end
      end

      S_DEL_RD: begin
        val_next = val_rdata;
        if (req_at_head) begin
          head_next  = step_ptr;
          link_we    = 1'b1;
          link_waddr = n_idx;
          link_wdata = free_ptr;
          val_we     = 1'b1;
          val_waddr  = n_idx;
          val_wdata  = '1;
          free_next  = PTR_W'(n_idx);
          finish     = 1'b1;
          fin_node   = n_idx;
          fin_val    = val_rdata;
        end else begin
          // bypass the removed node
          link_we    = 1'b1;
          link_waddr = req_pred;
          link_wdata = step_ptr;
          state_next = S_GIVE;
        end
      end

      S_GIVE: begin
        link_we    = 1'b1;
        link_waddr = n_idx;
        link_wdata = free_ptr;
        val_we     = 1'b1;
        val_waddr  = n_idx;
        val_wdata  = '1;
        free_next  = PTR_W'(n_idx);
        if ((req_op == pllm_pkg::OP_DEL_TAIL) && (pprev != NIL)) begin
          state_next = S_CUT;
        end else begin
          if (req_op == pllm_pkg::OP_DEL_TAIL) begin
            head_next = NIL;
          end
          finish   = 1'b1;
          fin_node = n_idx;
          fin_val  = val_reg;
        end
      end

      S_CUT: begin
        link_we    = 1'b1;
        link_waddr = pprev[IDX_W-1:0];
        link_wdata = NIL;
        finish     = 1'b1;
        fin_node   = n_idx;
        fin_val    = val_reg;
      end

      S_WALK_START: begin
        rd_addr    = head_ptr[IDX_W-1:0];
        prev_next  = head_ptr[IDX_W-1:0];
        pprev_next = NIL;
        steps_next = PTR_W'(1);
        state_next = S_WALK;
      end

      S_WALK: begin
        // link and value RAMs now hold the entries of prev
        if (step_flags.more) begin
          pprev_next = PTR_W'(prev);
          prev_next  = step_ptr[IDX_W-1:0];
          steps_next = step_inc;
          rd_addr    = step_ptr[IDX_W-1:0];
        end else if (req_op == pllm_pkg::OP_APPEND) begin
          link_we    = 1'b1;
          link_waddr = prev;
          link_wdata = PTR_W'(n_idx);
          finish     = 1'b1;
          fin_node   = n_idx;
          fin_val    = req_item;
        end else begin
          n_next     = prev;
          val_next   = val_rdata;
          state_next = S_GIVE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      state_next = S_IDLE;
    end
    done_next       = finish;
    res_status_next = fin_status;
    res_node_next   = fin_node;
    res_val_next    = fin_val;
    res_head_next   = head_next;
    res_free_next   = free_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      head_ptr <= NIL;
      free_ptr <= '0;
      clr_idx  <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      head_ptr <= head_next;
      free_ptr <= free_next;
      clr_idx  <= clr_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    n_idx   <= n_next;
    prev    <= prev_next;
    pprev   <= pprev_next;
    steps   <= steps_next;
    val_reg <= val_next;
    if (start && !busy) begin
      req_op      <= opcode;
      req_at_head <= at_head;
      req_pred    <= pred_index;
      req_item    <= $unsigned(item_value);
    end
    if (done_next) begin
      res_status <= res_status_next;
      res_node   <= res_node_next;
      res_val    <= res_val_next;
      res_head   <= res_head_next;
      res_free   <= res_free_next;
    end
  end

  assign status     = res_status;
  assign node_index = res_node;
  assign node_value = $signed(res_val);
  assign list_head  = res_head;
  assign free_head  = res_free;

  `PLLM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `PLLM_ASSERT(a_done_idle, !done || !busy, "result strobe while still busy")
  `PLLM_ASSERT(a_ptr_range, (head_ptr <= NIL) && (free_ptr <= NIL), "list pointer out of range")
  `PLLM_ASSERT(a_fail_zero, !done || (status == pllm_pkg::ST_OK) || ((node_index == '0) && (node_value == '0)), "failed request reports a node")
  `PLLM_ASSERT(a_walk_budget, (state != S_WALK) || ((steps != '0) && (steps <= NIL)), "walk step count out of range")

endmodule
